/* rtl/vbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_pkg
// shared types and constants of the breath cycle unit
// ----------------------------------------------------------------------------
package vbc_pkg;

  localparam int unsigned PeepDepthDefault    = 16;
  localparam int unsigned PlateauDepthDefault = 16;

  localparam logic [15:0] PeriodReset  = 16'd3000;
  localparam logic [14:0] TidalReset   = 15'd5000;
  localparam logic [15:0] PlimitReset  = 16'd6000;
  localparam logic [15:0] PlatMsReset  = 16'd200;

  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhInsuff  = 2'd1;
  localparam logic [1:0] PhPlateau = 2'd2;
  localparam logic [1:0] PhExhale  = 2'd3;

  localparam logic [1:0] RegPeriod = 2'd0;
  localparam logic [1:0] RegTidal  = 2'd1;
  localparam logic [1:0] RegPlimit = 2'd2;
  localparam logic [1:0] RegPlatMs = 2'd3;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] airway_pressure;
    logic signed [15:0] volume;
    logic               hold_done;
    logic               run;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic               cycle_start;
    logic               cycle_done;
    logic signed [15:0] peak_pressure;
    logic signed [15:0] plateau_pressure;
    logic signed [15:0] peep;
    logic [15:0]        ie_ratio;
    logic [15:0]        breath_rate;
    logic signed [15:0] exhaled_volume;
    logic signed [15:0] inhaled_volume;
    logic [15:0]        minute_volume;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/ventilator_breath_cycle_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ventilator_breath_cycle_unit
// volume-controlled breath sequencer, one result per sensor tick
// ----------------------------------------------------------------------------
// each tick transaction is taken in the idle state, where the phase logic
// runs, and its result is loaded into the output register from the output
// state once the previous result has been taken. a tick that ends a breath
// first runs three 40-bit restoring divisions (i:e ratio, rate, minute
// volume) one after another on one shared shift-subtract divider, then a
// breath-end step that goes idle or starts the next breath, before it
// reaches the output state. the input side is not ready while a tick is in
// work; a result still waiting in the output register holds the next tick
// in its last step until it is taken.
// the plateau and peep averages keep running sums; each breath start clears
// the sums and write pointers, so a ring slot not yet written this breath is
// read as zero through a per-slot valid bit. the floor average by the ring
// depth is a reciprocal multiplication on the sum magnitude.
module ventilator_breath_cycle_unit #(
  parameter int unsigned PEEP_DEPTH    = vbc_pkg::PeepDepthDefault,
  parameter int unsigned PLATEAU_DEPTH = vbc_pkg::PlateauDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire vbc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output vbc_pkg::out_item_t    out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned PlIdxW = (PLATEAU_DEPTH > 1) ? $clog2(PLATEAU_DEPTH) : 1;
  localparam int unsigned PpIdxW = (PEEP_DEPTH > 1) ? $clog2(PEEP_DEPTH) : 1;
  localparam int unsigned SumW   = 25;   // 16 bits plus up to 256 entries
  localparam int unsigned DivW   = 40;   // dividend width of the shared divider
  localparam logic [$clog2(DivW+1)-1:0] DivLast = ($clog2(DivW+1))'(DivW - 1);

  // floor(x / 3) for 16-bit x as (x * 43691) >> 17
  localparam logic [16:0] ThirdRecip = 17'd43691;

  // reciprocal of each ring depth, exact over the whole sum range
  localparam int unsigned PlShift = 2 * $clog2(PLATEAU_DEPTH) + 16;
  localparam int unsigned PpShift = 2 * $clog2(PEEP_DEPTH) + 16;
  localparam logic [24:0] PlRecip =
    25'(((64'd1 << PlShift) + 64'(PLATEAU_DEPTH) - 64'd1) / 64'(PLATEAU_DEPTH));
  localparam logic [24:0] PpRecip =
    25'(((64'd1 << PpShift) + 64'(PEEP_DEPTH) - 64'd1) / 64'(PEEP_DEPTH));
  localparam logic [8:0] PlDm1 = 9'(PLATEAU_DEPTH - 1);
  localparam logic [8:0] PpDm1 = 9'(PEEP_DEPTH - 1);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIVIE = 6'b000010,
    S_DIVRT = 6'b000100,
    S_DIVMV = 6'b001000,
    S_DIVRN = 6'b010000,
    S_OUT  = 6'b100000
  } seq_t;

  // configuration registers
  logic [15:0] period_r, plimit_r, platms_r;
  logic [14:0] tidal_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= vbc_pkg::PeriodReset;
      tidal_r  <= vbc_pkg::TidalReset;
      plimit_r <= vbc_pkg::PlimitReset;
      platms_r <= vbc_pkg::PlatMsReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        vbc_pkg::RegPeriod: period_r <= pwdata[15:0];
        vbc_pkg::RegTidal:  tidal_r  <= pwdata[14:0];
        vbc_pkg::RegPlimit: plimit_r <= pwdata[15:0];
        vbc_pkg::RegPlatMs: platms_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      vbc_pkg::RegPeriod: prdata = {16'd0, period_r};
      vbc_pkg::RegTidal:  prdata = {17'd0, tidal_r};
      vbc_pkg::RegPlimit: prdata = {16'd0, plimit_r};
      vbc_pkg::RegPlatMs: prdata = {16'd0, platms_r};
      default: prdata = '0;
    endcase
  end

  // breath state
  seq_t                state_r;
  logic [1:0]          phase_r;
  logic [31:0]         cyc_t0_r, ph_t0_r, elapsed_r;
  logic [15:0]         insp_lim_r;
  logic signed [15:0]  exh_v0_r, peak_r;
  logic signed [15:0]  plat_res_r, peep_res_r, exh_res_r, inh_res_r;
  logic [15:0]         ie_res_r, rate_res_r, min_res_r;
  logic signed [15:0]  plat_ring_r [PLATEAU_DEPTH];
  logic signed [15:0]  peep_ring_r [PEEP_DEPTH];
  logic [PLATEAU_DEPTH-1:0] plat_vld_r;
  logic [PEEP_DEPTH-1:0]    peep_vld_r;
  logic [PlIdxW-1:0]   plat_idx_r;
  logic [PpIdxW-1:0]   peep_idx_r;
  logic signed [SumW-1:0] plat_sum_r, peep_sum_r;
  logic                cs_r, done_r, run_r;
  logic [31:0]         now_r, ti_r;
  logic signed [15:0]  minv_r;    // saturated exhaled volume for minute volume

  // shared divider: restoring, one quotient bit per cycle
  logic [DivW-1:0]     dvd_r, quo_r;
  logic [32:0]         rem_r;
  logic [31:0]         dvs_r;
  logic [$clog2(DivW+1)-1:0] cnt_r;
  logic [32:0]         rem_sh;
  logic                rem_ge;
  assign rem_sh = {rem_r[31:0], dvd_r[DivW-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};

  function automatic logic [15:0] sat16(input logic [DivW-1:0] q);
    sat16 = (|q[DivW-1:16]) ? 16'hFFFF : q[15:0];
  endfunction

  // combinational tick evaluation
  logic signed [15:0] p, v;
  logic [31:0] e_now, e_ph;
  logic        over, to_plat, plat_end, fin;
  logic signed [16:0] exd;
  logic signed [15:0] exs;
  logic signed [15:0] plat_old, peep_old;
  logic signed [SumW-1:0] plat_avg_sum, peep_sum_new;
  logic [32:0] period_x3;
  logic [15:0] insp_third;

  assign p      = in_data.airway_pressure;
  assign v      = in_data.volume;
  assign e_now  = in_data.now_ms - cyc_t0_r;
  assign e_ph   = in_data.now_ms - ph_t0_r;
  assign over   = p >= $signed(plimit_r);
  assign to_plat = (v >= $signed({1'b0, tidal_r})) || (e_now >= {16'd0, insp_lim_r});
  assign plat_end = over || (in_data.hold_done && e_ph >= {16'd0, platms_r});
  assign fin    = e_now >= {16'd0, period_r};
  assign exd    = 17'(exh_v0_r) - 17'(v);
  assign exs    = (exd > 17'sd32767) ? 16'sh7FFF :
                  (exd < -17'sd32768) ? -16'sh8000 : exd[15:0];
  assign plat_old = plat_vld_r[plat_idx_r] ? plat_ring_r[plat_idx_r] : 16'sd0;
  assign peep_old = peep_vld_r[peep_idx_r] ? peep_ring_r[peep_idx_r] : 16'sd0;
  assign peep_sum_new = peep_sum_r + SumW'(p) - SumW'(peep_old);
  assign plat_avg_sum = plat_sum_r;
  assign period_x3  = 33'(period_r) * 33'(ThirdRecip);
  assign insp_third = period_x3[32:17];

  // floor average: magnitude times the depth reciprocal, a negative sum is
  // biased by depth - 1 first so the quotient rounds toward minus infinity
  function automatic logic signed [15:0] favg(input logic signed [SumW-1:0] s,
                                              input logic [24:0] recip,
                                              input int unsigned shift,
                                              input logic [8:0] dm1);
    logic [SumW-1:0]  mag;
    logic [SumW+24:0] prod;
    logic [SumW+24:0] q;
    mag  = s[SumW-1] ? (SumW'(-s) + SumW'(dm1)) : SumW'(s);
    prod = (SumW+25)'(mag) * (SumW+25)'(recip);
    q    = prod >> shift;
    favg = s[SumW-1] ? -q[15:0] : q[15:0];
  endfunction

  wire accept = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);

  // output register, loaded once the previous result has been taken
  vbc_pkg::out_item_t res_now;
  vbc_pkg::out_item_t out_r;
  logic out_valid_r;
  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= vbc_pkg::PhIdle;
      cyc_t0_r <= '0; ph_t0_r <= '0; insp_lim_r <= '0; exh_v0_r <= '0;
      peak_r <= '0; plat_res_r <= '0; peep_res_r <= '0; exh_res_r <= '0;
      inh_res_r <= '0; ie_res_r <= '0; rate_res_r <= '0; min_res_r <= '0;
      plat_vld_r <= '0; peep_vld_r <= '0; plat_idx_r <= '0; peep_idx_r <= '0;
      plat_sum_r <= '0; peep_sum_r <= '0;
      cs_r <= 1'b0; done_r <= 1'b0; run_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (accept) begin
          cs_r <= (phase_r == vbc_pkg::PhIdle) && in_data.run;
          done_r <= (phase_r == vbc_pkg::PhExhale) && fin;
          state_r <= ((phase_r == vbc_pkg::PhExhale) && fin) ? S_DIVIE : S_OUT;
          unique case (phase_r)
            vbc_pkg::PhIdle: if (in_data.run) begin
              peak_r <= '0; plat_res_r <= '0; peep_res_r <= '0;
              ie_res_r <= '0; rate_res_r <= '0; exh_res_r <= '0;
              phase_r <= vbc_pkg::PhInsuff;
              cyc_t0_r <= in_data.now_ms; ph_t0_r <= in_data.now_ms;
              insp_lim_r <= insp_third;
              plat_vld_r <= '0; peep_vld_r <= '0;
              plat_idx_r <= '0; peep_idx_r <= '0;
              plat_sum_r <= '0; peep_sum_r <= '0;
            end
            vbc_pkg::PhInsuff: begin
              if (over) begin
                phase_r <= vbc_pkg::PhExhale; ph_t0_r <= in_data.now_ms;
                exh_v0_r <= v; inh_res_r <= v;
              end else if (to_plat) begin
                phase_r <= vbc_pkg::PhPlateau; ph_t0_r <= in_data.now_ms;
              end else if (p > peak_r) begin
                peak_r <= p;
              end
            end
            vbc_pkg::PhPlateau: begin
              if (plat_end) begin
                plat_res_r <= favg(plat_avg_sum, PlRecip, PlShift, PlDm1);
                phase_r <= vbc_pkg::PhExhale; ph_t0_r <= in_data.now_ms;
                exh_v0_r <= v; inh_res_r <= v;
              end
              plat_sum_r <= plat_sum_r + SumW'(p) - SumW'(plat_old);
              plat_ring_r[plat_idx_r] <= p;
              plat_vld_r[plat_idx_r] <= 1'b1;
              plat_idx_r <= (32'(plat_idx_r) == PLATEAU_DEPTH - 1) ? '0
                            : plat_idx_r + 1'b1;
              if (p > peak_r) peak_r <= p;
            end
            default: begin
              peep_sum_r <= peep_sum_new;
              peep_ring_r[peep_idx_r] <= p;
              peep_vld_r[peep_idx_r] <= 1'b1;
              peep_idx_r <= (32'(peep_idx_r) == PEEP_DEPTH - 1) ? '0
                            : peep_idx_r + 1'b1;
              if (fin) begin
                peep_res_r <= favg(peep_sum_r, PpRecip, PpShift, PpDm1);
                exh_res_r <= exs; minv_r <= exs;
                elapsed_r <= e_now;
                ti_r <= ph_t0_r - cyc_t0_r;
                now_r <= in_data.now_ms; run_r <= in_data.run;
                // start i:e divide: (e << 8) / ti
                dvd_r <= {e_now, 8'd0}; dvs_r <= ph_t0_r - cyc_t0_r;
                rem_r <= '0; cnt_r <= '0;
              end
            end
          endcase
        end
        S_DIVIE, S_DIVRT, S_DIVMV: begin
          quo_r <= {quo_r[DivW-2:0], rem_ge};
          if (cnt_r != DivLast) begin
            rem_r <= rem_ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
            dvd_r <= {dvd_r[DivW-2:0], 1'b0};
            cnt_r <= cnt_r + 1'b1;
          end else begin
            cnt_r <= '0; rem_r <= '0;
            if (state_r == S_DIVIE) begin
              ie_res_r <= (ti_r == 0) ? 16'hFFFF : sat16({quo_r[DivW-2:0], rem_ge});
              dvd_r <= DivW'(60000 * 256); dvs_r <= elapsed_r;
              state_r <= S_DIVRT;
            end else if (state_r == S_DIVRT) begin
              rate_res_r <= (elapsed_r == 0) ? 16'hFFFF
                            : sat16({quo_r[DivW-2:0], rem_ge});
              dvd_r <= DivW'(minv_r[14:0]) * DivW'(600); dvs_r <= elapsed_r;
              state_r <= S_DIVMV;
            end else begin
              min_res_r <= (minv_r <= 0) ? 16'd0 : (elapsed_r == 0) ? 16'hFFFF
                           : sat16({quo_r[DivW-2:0], rem_ge});
              state_r <= S_DIVRN;
            end
          end
        end
        S_DIVRN: begin
          // breath end: go idle or start the next breath on the same tick
          if (run_r) begin
            phase_r <= vbc_pkg::PhInsuff; cs_r <= 1'b1;
            cyc_t0_r <= now_r; ph_t0_r <= now_r;
            insp_lim_r <= insp_third;
            plat_vld_r <= '0; peep_vld_r <= '0;
            plat_idx_r <= '0; peep_idx_r <= '0;
            plat_sum_r <= '0; peep_sum_r <= '0;
          end else begin
            phase_r <= vbc_pkg::PhIdle;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // wait here while the previous result is still held
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_now.phase            = phase_r;
    res_now.cycle_start      = cs_r;
    res_now.cycle_done       = done_r;
    res_now.peak_pressure    = peak_r;
    res_now.plateau_pressure = plat_res_r;
    res_now.peep             = peep_res_r;
    res_now.ie_ratio         = ie_res_r;
    res_now.breath_rate      = rate_res_r;
    res_now.exhaled_volume   = exh_res_r;
    res_now.inhaled_volume   = inh_res_r;
    res_now.minute_volume    = min_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_r <= '0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
      out_r <= res_now;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression bench for ventilator_breath_cycle_unit: ticks driven through a
// valid/ready channel, each result checked against an in-bench breath model
// ----------------------------------------------------------------------------
module tb;
  import vbc_pkg::*;

  localparam int Depth    = 16;
  localparam int WdLimit  = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ventilator_breath_cycle_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // live copy of the configuration registers
  logic [15:0]        period_ms;
  logic [14:0]        tidal;
  logic signed [15:0] plimit;
  logic [15:0]        hold_ms;

  // breath model state
  logic [1:0]  br_phase;
  logic [31:0] t_cycle;
  logic [31:0] t_phase;
  logic [31:0] insp_lim;
  int          exh_start_vol;
  int          peak;
  int          r_plat, r_peep, r_ie, r_rate, r_exh, r_inh, r_min;
  int          plat_ring [Depth];
  int          peep_ring [Depth];
  int          plat_idx, peep_idx, plat_sum, peep_sum;

  out_item_t   expected_q[$];
  int          errors;
  int          quiet_cycles;
  bit          calm;
  logic [31:0] clock_ms;
  int          step_max;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int avg_floor(int s);
    int q;
    q = s / Depth;
    if ((s % Depth) != 0 && s < 0) q--;
    return q;
  endfunction

  function automatic int sat16u(longint unsigned v);
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  function automatic void clear_rings();
    for (int k = 0; k < Depth; k++) begin
      plat_ring[k] = 0;
      peep_ring[k] = 0;
    end
    plat_idx = 0;
    peep_idx = 0;
    plat_sum = 0;
    peep_sum = 0;
  endfunction

  function automatic void begin_breath(logic [31:0] now);
    br_phase = PhInsuff;
    t_cycle  = now;
    t_phase  = now;
    insp_lim = period_ms / 3;
    clear_rings();
  endfunction

  function automatic void go_exhale(logic [31:0] now, int v);
    br_phase      = PhExhale;
    t_phase       = now;
    exh_start_vol = v;
    r_inh         = v;
  endfunction

  // one tick through the breath model
  function automatic out_item_t breath_step(in_item_t it);
    out_item_t   r;
    int          p, v, ex;
    logic [31:0] e, ti;
    bit          cs, done;
    p    = it.airway_pressure;
    v    = it.volume;
    cs   = 0;
    done = 0;
    case (br_phase)
      PhIdle: begin
        if (it.run) begin
          peak = 0; r_plat = 0; r_peep = 0; r_ie = 0; r_rate = 0; r_exh = 0;
          begin_breath(it.now_ms);
          cs = 1;
        end
      end
      PhInsuff: begin
        if (p >= plimit) begin
          go_exhale(it.now_ms, v);
        end else if (v >= int'(tidal) || (it.now_ms - t_cycle) >= insp_lim) begin
          br_phase = PhPlateau;
          t_phase  = it.now_ms;
        end else if (p > peak) begin
          peak = p;
        end
      end
      PhPlateau: begin
        if (p >= plimit || (it.hold_done && (it.now_ms - t_phase) >= hold_ms)) begin
          r_plat = avg_floor(plat_sum);
          go_exhale(it.now_ms, v);
        end
        plat_sum += p - plat_ring[plat_idx];
        plat_ring[plat_idx] = p;
        plat_idx = (plat_idx + 1) % Depth;
        if (p > peak) peak = p;
      end
      default: begin
        e = it.now_ms - t_cycle;
        if (e >= period_ms) begin
          ti     = t_phase - t_cycle;
          r_peep = avg_floor(peep_sum);
          r_ie   = (ti == 0) ? 65535 : sat16u((longint'(e) << 8) / ti);
          r_rate = (e == 0) ? 65535 : sat16u(64'd15360000 / e);
          ex = exh_start_vol - v;
          if (ex > 32767) ex = 32767;
          if (ex < -32768) ex = -32768;
          r_exh = ex;
          if (ex <= 0) r_min = 0;
          else if (e == 0) r_min = 65535;
          else r_min = sat16u(longint'(ex) * 600 / e);
          done = 1;
        end
        peep_sum += p - peep_ring[peep_idx];
        peep_ring[peep_idx] = p;
        peep_idx = (peep_idx + 1) % Depth;
        if (done) begin
          if (it.run) begin
            begin_breath(it.now_ms);
            cs = 1;
          end else begin
            br_phase = PhIdle;
          end
        end
      end
    endcase
    r.phase            = br_phase;
    r.cycle_start      = cs;
    r.cycle_done       = done;
    r.peak_pressure    = peak[15:0];
    r.plateau_pressure = r_plat[15:0];
    r.peep             = r_peep[15:0];
    r.ie_ratio         = r_ie[15:0];
    r.breath_rate      = r_rate[15:0];
    r.exhaled_volume   = r_exh[15:0];
    r.inhaled_volume   = r_inh[15:0];
    r.minute_volume    = r_min[15:0];
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // model advances on every accepted tick transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_q.push_back(breath_step(in_data));
  end

  // result checker
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result at %0t", $realtime);
      end else begin
        w = expected_q.pop_front();
        if (out_data.phase != w.phase) report("phase", out_data.phase, w.phase);
        if (out_data.cycle_start != w.cycle_start)
          report("cycle_start", out_data.cycle_start, w.cycle_start);
        if (out_data.cycle_done != w.cycle_done)
          report("cycle_done", out_data.cycle_done, w.cycle_done);
        if (out_data.peak_pressure != w.peak_pressure)
          report("peak_pressure", out_data.peak_pressure, w.peak_pressure);
        if (out_data.plateau_pressure != w.plateau_pressure)
          report("plateau_pressure", out_data.plateau_pressure, w.plateau_pressure);
        if (out_data.peep != w.peep) report("peep", out_data.peep, w.peep);
        if (out_data.ie_ratio != w.ie_ratio) report("ie_ratio", out_data.ie_ratio, w.ie_ratio);
        if (out_data.breath_rate != w.breath_rate)
          report("breath_rate", out_data.breath_rate, w.breath_rate);
        if (out_data.exhaled_volume != w.exhaled_volume)
          report("exhaled_volume", out_data.exhaled_volume, w.exhaled_volume);
        if (out_data.inhaled_volume != w.inhaled_volume)
          report("inhaled_volume", out_data.inhaled_volume, w.inhaled_volume);
        if (out_data.minute_volume != w.minute_volume)
          report("minute_volume", out_data.minute_volume, w.minute_volume);
      end
    end
  end

  // receiver stalls, none during a calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 29);
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WdLimit) begin
      $display("ventilator_breath_cycle_unit regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      RegPeriod: period_ms = val[15:0];
      RegTidal:  tidal     = val[14:0];
      RegPlimit: plimit    = val[15:0];
      default:   hold_ms   = val[15:0];
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_tick(in_item_t it);
    int gap;
    gap = (calm || $urandom_range(0, 99) >= 29) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop driving ticks, wait for every expected result, then wait on idle
  task automatic settle();
    @(negedge clk);
    in_valid = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(int per, int tv, int pl, int hm);
    settle();
    cfg_write(RegPeriod, per);
    cfg_write(RegTidal, tv);
    cfg_write(RegPlimit, pl);
    cfg_write(RegPlatMs, hm);
  endtask

  function automatic in_item_t make_tick(logic [31:0] now, int p, int v, bit hd, bit rn);
    in_item_t it;
    it.now_ms = now;
    it.airway_pressure = p[15:0];
    it.volume = v[15:0];
    it.hold_done = hd;
    it.run = rn;
    return it;
  endfunction

  // random tick, mostly a plausible breath with some noise mixed in
  function automatic in_item_t rand_tick();
    int p, v;
    if ($urandom_range(0, 99) == 0) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, step_max);
    p = ($urandom_range(0, 9) == 0) ? $signed($urandom_range(0, 65535)) - 32768
                                    : int'(plimit) - 2000 + $urandom_range(0, 2100);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                    : $urandom_range(0, int'(tidal) + 200);
    if (v > 32767) v = 32767;
    return make_tick(clock_ms, p, v, $urandom_range(0, 3) != 0, $urandom_range(0, 9) != 0);
  endfunction

  task automatic test_directed();
    // zero period: zero inspiration and cycle time, saturated ratio and rate
    set_config(0, 0, 32767, 0);
    send_tick(make_tick(32'd10, 0, 0, 0, 0));
    send_tick(make_tick(32'd10, 0, 0, 0, 1));
    send_tick(make_tick(32'd10, 32767, 32767, 1, 1));
    send_tick(make_tick(32'd10, -32768, -32768, 1, 0));
    // overpressure straight from insufflation, negative exhaled volume
    set_config(20, 100, 500, 5);
    send_tick(make_tick(32'hFFFF_FFF0, 0, 0, 0, 1));
    send_tick(make_tick(32'hFFFF_FFF4, 600, -32768, 0, 0));
    send_tick(make_tick(32'h0000_0010, -32768, 32767, 1, 0));
    // full breath through plateau, hold not yet done, run dropped mid-breath
    send_tick(make_tick(32'h20, 0, 0, 0, 1));
    send_tick(make_tick(32'h21, 200, 50, 0, 0));
    send_tick(make_tick(32'h22, 300, 150, 0, 0));
    send_tick(make_tick(32'h23, 310, 150, 0, 0));
    send_tick(make_tick(32'h2A, 320, 150, 1, 0));
    send_tick(make_tick(32'h30, 20, -32768, 0, 1));
    send_tick(make_tick(32'h38, 10, 0, 0, 1));
    send_tick(make_tick(32'h40, 30, 100, 0, 1));
    send_tick(make_tick(32'h41, 40, 32767, 1, 1));
    send_tick(make_tick(32'h48, 499, 10, 1, 1));
    send_tick(make_tick(32'h60, -100, -32768, 0, 1));
  endtask

  task automatic test_random(int per, int tv, int pl, int hm, int smax, int n);
    set_config(per, tv, pl, hm);
    step_max = smax;
    for (int k = 0; k < n; k++) begin
      calm = (k >= n / 2) && (k < n / 2 + 60);
      send_tick(rand_tick());
    end
    calm = 0;
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    errors = 0; quiet_cycles = 0; calm = 0; clock_ms = 0; step_max = 1;
    period_ms = PeriodReset; tidal = TidalReset; plimit = PlimitReset; hold_ms = PlatMsReset;
    br_phase = PhIdle; t_cycle = 0; t_phase = 0; insp_lim = 0; exh_start_vol = 0; peak = 0;
    r_plat = 0; r_peep = 0; r_ie = 0; r_rate = 0; r_exh = 0; r_inh = 0; r_min = 0;
    clear_rings();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // reset values first, no register written yet
    step_max = 300;
    for (int k = 0; k < 60; k++) send_tick(rand_tick());
    test_directed();
    test_random(30, 400, 3000, 5, 8, 450);
    test_random(65535, 32767, 32767, 65535, 20000, 300);
    test_random(0, 0, -32768, 0, 3, 250);
    test_random(100, 5000, 6000, 20, 12, 450);
    test_random(3000, 2000, 4000, 200, 300, 450);
    settle();
    if (errors == 0) begin
      $display("ventilator_breath_cycle_unit regression: pass");
    end else begin
      $display("ventilator_breath_cycle_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/vbc_pkg.sv
rtl/ventilator_breath_cycle_unit.sv
tb/sv/tb.sv
